### hw/rtl/loj_pkg.sv
// Package: shared constants and types for the label overlap block.
package loj_pkg;
  localparam int MAX_FEATURES_A_DEF = 8;
  localparam int MAX_FEATURES_B_DEF = 8;
  localparam int COUNT_BITS_DEF     = 20;
  localparam int RESULT_LIMIT       = 64;
  localparam int LABEL_W            = 3;
  localparam int CFG_W              = 4;
  localparam int FRAC_W             = 17;
  localparam logic [0:0] CFG_IDX_A = 1'b0;
  localparam logic [0:0] CFG_IDX_B = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

### hw/rtl/loj_if.sv
// Interfaces: voxel input channel and result output channel.
interface loj_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] label_a;
  logic [2:0] label_b;
  logic       last_voxel;
  modport source (output valid, label_a, label_b, last_voxel, input ready);
  modport sink   (input valid, label_a, label_b, last_voxel, output ready);
endinterface

interface loj_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index_a;
  logic [2:0]  index_b;
  logic [16:0] jaccard_frac;
  logic [16:0] dissimilarity_frac;
  logic        undefined_ratio;
  logic        last_result;
  modport source (output valid, index_a, index_b, jaccard_frac, dissimilarity_frac,
                  undefined_ratio, last_result, input ready);
  modport sink   (input valid, index_a, index_b, jaccard_frac, dissimilarity_frac,
                  undefined_ratio, last_result, output ready);
endinterface

### hw/rtl/label_overlap_jaccard.sv
// Top level: joint label histogram with Jaccard / dissimilarity readout.
//
// Usage: voxels enter on in_* (valid/ready), one word per voxel carrying a
// label from each segmentation and a last_voxel flag. Each voxel is read from
// memory, updated and written back; ready drops meanwhile. Labels at
// or above the in-use register value are dropped; counts saturate.
// After the last voxel the block walks every pair in use (a outer, b inner,
// at most 64 pairs) and sends one result word per pair on out_*. Each pair
// reads its counts (S_RD, S_RD2) and checks for an undefined ratio (S_DV1),
// then runs two divisions on one shared restoring divider (COUNT_BITS+18
// quotient steps each); a pair with both counts zero skips the divider.
// Results sit in an output register; if the receiver stalls, the sequencer
// waits there. After the final pair a clearing pass over all MAX_A*MAX_B entries
// zeroes the pair memory and the side counters before new voxels are taken.
// Reset: synchronous, active low; both in-use registers go to 8 and a
// clearing pass runs first (input not ready).
// Configuration: cfg_we/cfg_idx/cfg_wdata, index 0 = A in use, 1 = B in use;
// write only while idle.
module label_overlap_jaccard #(
  parameter int MAX_FEATURES_A = loj_pkg::MAX_FEATURES_A_DEF,
  parameter int MAX_FEATURES_B = loj_pkg::MAX_FEATURES_B_DEF,
  parameter int COUNT_BITS     = loj_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_idx,
  input  logic [loj_pkg::CFG_W-1:0] cfg_wdata,
  loj_in_if.sink                    in_ch,
  loj_out_if.source                 out_ch
);
  import loj_pkg::*;

  localparam int DEPTH = MAX_FEATURES_A * MAX_FEATURES_B;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IAW   = (MAX_FEATURES_A > 1) ? $clog2(MAX_FEATURES_A) : 1;
  localparam int IBW   = (MAX_FEATURES_B > 1) ? $clog2(MAX_FEATURES_B) : 1;
  localparam int NAW   = $clog2(MAX_FEATURES_A + 1);
  localparam int NBW   = $clog2(MAX_FEATURES_B + 1);
  localparam int RCW   = $clog2(RESULT_LIMIT + 1);
  localparam int CB    = COUNT_BITS;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ACC1 = 4'd2;
  localparam logic [3:0] S_ACC2 = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_DV1  = 4'd6;
  localparam logic [3:0] S_DV1W = 4'd7;
  localparam logic [3:0] S_DV2W = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [CFG_W-1:0] cfg_a_r, cfg_b_r;
  logic [3:0]       st_r;

  // Pair count memory: one write port, one registered read port.
  logic [CB-1:0] pmem [DEPTH];
  logic [AW-1:0] paddr;
  logic          pwe;
  logic [CB-1:0] pwdata, prdata_r;

  logic [CB-1:0] cnt_a_r [MAX_FEATURES_A];
  logic [CB-1:0] cnt_b_r [MAX_FEATURES_B];

  logic [AW-1:0]  clr_r;
  logic [LABEL_W-1:0] la_r, lb_r;
  logic           va_r, vb_r, last_r;
  logic [IAW-1:0] ia_r;
  logic [IBW-1:0] ib_r;
  logic [RCW-1:0] rcnt_r;
  logic [CB-1:0]  ov_r, ca_r, cb_r;
  logic [16:0]    jac_r;

  logic [NAW-1:0] na;
  logic [NBW-1:0] nb;
  logic           va, vb;
  logic [IAW-1:0] in_la;
  logic [IBW-1:0] in_lb;
  logic [CB-1:0]  ov_c, den_c, num_c, ea, eb;
  logic [CB:0]    uni_w;
  logic           undef_c;
  logic [RCW-1:0] total;
  logic [2*RCW+1:0] prod;

  // divider runs one bit wider: the union can exceed a single count
  logic           dv_start, dv_done;
  logic [CB:0]    dv_num, dv_den;
  logic [CB+17:0] dv_q;
  logic [16:0]    q_sat;

  assign na = (32'(cfg_a_r) > 32'(MAX_FEATURES_A)) ? NAW'(MAX_FEATURES_A) : NAW'(cfg_a_r);
  assign nb = (32'(cfg_b_r) > 32'(MAX_FEATURES_B)) ? NBW'(MAX_FEATURES_B) : NBW'(cfg_b_r);
  assign prod  = (2*RCW+2)'(na) * (2*RCW+2)'(nb);
  assign total = (prod > (2*RCW+2)'(RESULT_LIMIT)) ? RCW'(RESULT_LIMIT) : RCW'(prod);
  assign va = 32'(in_ch.label_a) < 32'(na);
  assign vb = 32'(in_ch.label_b) < 32'(nb);
  assign in_la = IAW'(in_ch.label_a);
  assign in_lb = IBW'(in_ch.label_b);

  // pair arithmetic on registered counts
  always_comb begin
    ov_c = ov_r;
    if (ov_c > ca_r) ov_c = ca_r;
    if (ov_c > cb_r) ov_c = cb_r;
    uni_w = {1'b0, ca_r} + {1'b0, cb_r} - {1'b0, ov_c};
    den_c = (ca_r > cb_r) ? ca_r : cb_r;
    ea    = ca_r - ov_c;
    eb    = cb_r - ov_c;
    num_c = (ea > eb) ? ea : eb;
    undef_c = (ca_r == '0) && (cb_r == '0);
  end

  assign q_sat = (dv_q > (CB+18)'(65536)) ? 17'd65536 : dv_q[16:0];

  logic [IAW-1:0] pla;
  logic [IBW-1:0] plb;
  assign pla = IAW'(la_r);
  assign plb = IBW'(lb_r);

  always_comb begin
    paddr  = AW'(ia_r) * AW'(MAX_FEATURES_B) + AW'(ib_r);
    pwe    = 1'b0;
    pwdata = (prdata_r == CMAX) ? CMAX : prdata_r + 1'b1;
    dv_start = 1'b0;
    dv_num = {1'b0, ov_c};
    dv_den = uni_w;
    unique case (st_r)
      S_CLR: begin
        paddr = clr_r; pwe = 1'b1; pwdata = '0;
      end
      S_IDLE: paddr = AW'(in_la) * AW'(MAX_FEATURES_B) + AW'(in_lb);
      S_ACC1, S_ACC2: begin
        paddr = AW'(pla) * AW'(MAX_FEATURES_B) + AW'(plb);
        pwe   = (st_r == S_ACC2) && va_r && vb_r;
      end
      S_DV1: dv_start = !undef_c;
      S_DV1W: begin
        dv_start = dv_done;
        dv_num = {1'b0, num_c}; dv_den = {1'b0, den_c};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwe) pmem[paddr] <= pwdata;
    prdata_r <= pmem[paddr];
  end

  loj_div #(.CB(CB + 1)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_q)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      clr_r   <= '0;
      cfg_a_r <= CFG_W'(8);
      cfg_b_r <= CFG_W'(8);
      ia_r    <= '0;
      ib_r    <= '0;
      rcnt_r  <= '0;
      for (int i = 0; i < MAX_FEATURES_A; i++) cnt_a_r[i] <= '0;
      for (int j = 0; j < MAX_FEATURES_B; j++) cnt_b_r[j] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_IDX_A) cfg_a_r <= cfg_wdata;
        else                      cfg_b_r <= cfg_wdata;
      end
      unique case (st_r)
        S_CLR: begin
          for (int i = 0; i < MAX_FEATURES_A; i++) cnt_a_r[i] <= '0;
          for (int j = 0; j < MAX_FEATURES_B; j++) cnt_b_r[j] <= '0;
          if (clr_r == AW'(DEPTH - 1)) begin
            clr_r <= '0;
            st_r  <= S_IDLE;
          end else clr_r <= clr_r + 1'b1;
        end
        S_IDLE: if (in_ch.valid) begin
          la_r <= in_ch.label_a; lb_r <= in_ch.label_b;
          va_r <= va; vb_r <= vb; last_r <= in_ch.last_voxel;
          if (va && cnt_a_r[in_la] != CMAX)
            cnt_a_r[in_la] <= cnt_a_r[in_la] + 1'b1;
          if (vb && cnt_b_r[in_lb] != CMAX)
            cnt_b_r[in_lb] <= cnt_b_r[in_lb] + 1'b1;
          st_r <= S_ACC1;
        end
        S_ACC1: st_r <= S_ACC2;
        S_ACC2: begin
          ia_r <= '0; ib_r <= '0; rcnt_r <= '0;
          if (!last_r) st_r <= S_IDLE;
          else if (total == '0) st_r <= S_CLR;
          else st_r <= S_RD;
        end
        S_RD: st_r <= S_RD2;
        S_RD2: begin
          ov_r <= prdata_r;
          ca_r <= cnt_a_r[ia_r];
          cb_r <= cnt_b_r[ib_r];
          st_r <= S_DV1;
        end
        S_DV1: begin
          if (undef_c) begin
            jac_r <= '0;
            out_ch.jaccard_frac <= '0;
            out_ch.dissimilarity_frac <= '0;
            st_r <= S_OUT;
          end else st_r <= S_DV1W;
          out_ch.undefined_ratio <= undef_c;
          out_ch.index_a <= LABEL_W'(ia_r);
          out_ch.index_b <= LABEL_W'(ib_r);
          out_ch.last_result <= (rcnt_r + 1'b1) == total;
        end
        S_DV1W: if (dv_done) begin
          jac_r <= q_sat;
          st_r  <= S_DV2W;
        end
        S_DV2W: if (dv_done) begin
          out_ch.jaccard_frac       <= jac_r;
          out_ch.dissimilarity_frac <= q_sat;
          st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          rcnt_r <= rcnt_r + 1'b1;
          if ((rcnt_r + 1'b1) == total) st_r <= S_CLR;
          else begin
            st_r <= S_RD;
            if (NBW'(ib_r) == NBW'(nb - 1'b1)) begin
              ib_r <= '0;
              ia_r <= ia_r + 1'b1;
            end else ib_r <= ib_r + 1'b1;
          end
        end
        default: st_r <= S_CLR;
      endcase
    end
  end
endmodule

### hw/rtl/loj_div.sv
// Restoring divider: floor((num << 16) / den), one quotient bit per cycle.
module loj_div #(
  parameter int CB = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [CB-1:0]  num,
  input  logic [CB-1:0]  den,
  output logic           done,
  output logic [CB+16:0] quot
);
  import loj_pkg::*;
  localparam int QW = CB + 17;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [CB:0]   rem_r, rem_nxt;
  logic [CB-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CB+1:0] trial;
  logic [CB:0]   shifted;

  always_comb begin
    shifted  = {rem_r[CB-1:0], dvd_r[QW-1]};
    trial    = {1'b0, shifted} - {2'b0, den_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {1'b0, num, 16'b0};
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[CB+1]) begin
        rem_nxt = trial[CB:0];
        dvd_nxt = {dvd_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
endmodule

### tb/label_overlap_jaccard_tb.sv
// Testbench for label_overlap_jaccard: directed and random voxel runs checked against a histogram predictor.
`timescale 1ns / 100ps

module label_overlap_jaccard_tb;
  import loj_pkg::*;

  typedef struct packed {
    logic [2:0] label_a;
    logic [2:0] label_b;
    logic       last_voxel;
  } voxel_t;

  typedef struct packed {
    logic [2:0]  index_a;
    logic [2:0]  index_b;
    logic [16:0] jaccard_frac;
    logic [16:0] dissimilarity_frac;
    logic        undefined_ratio;
    logic        last_result;
  } overlap_t;

  localparam int  CNT_W      = COUNT_BITS_DEF;
  localparam int  CYCLE_CAP  = 20_000_000;
  localparam bit [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = CFG_IDX_A;
  logic [CFG_W-1:0] cfg_wdata = '0;

  loj_in_if  in_ch ();
  loj_out_if out_ch ();

  label_overlap_jaccard u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow histogram and in-use settings.
  logic [CFG_W-1:0] used_a = 4'd8, used_b = 4'd8;
  logic [CNT_W-1:0] joint_hist [0:63];
  logic [CNT_W-1:0] hist_a [0:7];
  logic [CNT_W-1:0] hist_b [0:7];

  voxel_t   voxel_q [$];
  overlap_t overlap_q [$];

  int errors = 0;
  int n_words_in = 0;
  int n_results = 0;
  int n_undef = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [16:0] q16_div(longint unsigned num, longint unsigned den);
    longint unsigned r;
    r = (num << 16) / den;
    return (r > 65536) ? 17'd65536 : r[16:0];
  endfunction

  // Accumulate one voxel; on the last voxel, queue every pair's overlap.
  task automatic predict_overlap(input voxel_t v);
    int na, nb, total, n;
    longint unsigned ov, ca, cb, uni, den, ea, eb;
    overlap_t r;
    na = (used_a > 8) ? 8 : used_a;
    nb = (used_b > 8) ? 8 : used_b;
    if (v.label_a < na && hist_a[v.label_a] != CNT_SAT) hist_a[v.label_a]++;
    if (v.label_b < nb && hist_b[v.label_b] != CNT_SAT) hist_b[v.label_b]++;
    if (v.label_a < na && v.label_b < nb && joint_hist[v.label_a*8+v.label_b] != CNT_SAT)
      joint_hist[v.label_a*8+v.label_b]++;
    if (!v.last_voxel) return;
    total = na * nb;
    if (total > RESULT_LIMIT) total = RESULT_LIMIT;
    n = 0;
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < nb; j++) begin
        if (n < total) begin
          ov = joint_hist[i*8+j];
          ca = hist_a[i];
          cb = hist_b[j];
          if (ov > ca) ov = ca;
          if (ov > cb) ov = cb;
          uni = ca + cb - ov;
          den = (ca > cb) ? ca : cb;
          ea = ca - ov;
          eb = cb - ov;
          r.index_a = i[2:0];
          r.index_b = j[2:0];
          if (uni == 0 || den == 0) begin
            r.jaccard_frac = '0;
            r.dissimilarity_frac = '0;
            r.undefined_ratio = 1'b1;
          end else begin
            r.jaccard_frac = q16_div(ov, uni);
            r.dissimilarity_frac = q16_div((ea > eb) ? ea : eb, den);
            r.undefined_ratio = 1'b0;
          end
          n++;
          r.last_result = (n == total);
          overlap_q.push_back(r);
        end
      end
    end
    for (int k = 0; k < 64; k++) joint_hist[k] = '0;
    for (int k = 0; k < 8; k++) begin
      hist_a[k] = '0;
      hist_b[k] = '0;
    end
  endtask

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // The word on the bus was taken at the last rising edge when valid was
  // seen with ready.
  bit taken_flag = 1'b0;
  always @(posedge clk) taken_flag <= rst_n && in_ch.valid && in_ch.ready;
  function automatic bit offered_taken();
    return taken_flag;
  endfunction

  // Driver: offer queued words; prediction happens on acceptance.
  int drv_gap = 0;
  bit drv_burst = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.label_a = '0;
    in_ch.label_b = '0;
    in_ch.last_voxel = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_overlap({in_ch.label_a, in_ch.label_b, in_ch.last_voxel});
      void'(voxel_q.pop_front());
      n_words_in++;
    end
  end

  // Valid handling runs at the falling edge, after the acceptance above.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (voxel_q.size() > 0 && (!in_ch.valid || offered_taken())) begin
      if (!drv_burst && in_ch.valid == 1'b0 && pick_gap() > 0 && $urandom_range(1)) begin
        drv_gap <= pick_gap();
        in_ch.valid <= 1'b0;
      end else begin
        {in_ch.label_a, in_ch.label_b, in_ch.last_voxel} <= voxel_q[0];
        in_ch.valid <= 1'b1;
      end
    end else if (voxel_q.size() == 0) begin
      in_ch.valid <= 1'b0;
    end
  end

  // Monitor: ready with random stalls, plus one long hold-off when asked.
  int snk_gap = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (drv_burst) begin
      out_ch.ready <= 1'b1;
    end else begin
      snk_gap <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    overlap_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.index_a, out_ch.index_b, out_ch.jaccard_frac,
             out_ch.dissimilarity_frac, out_ch.undefined_ratio, out_ch.last_result};
      n_results++;
      if (got.undefined_ratio) n_undef++;
      if (overlap_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
      end else begin
        want = overlap_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch pair (%0d,%0d): exp j=%0d d=%0d u=%0b l=%0b got (%0d,%0d) j=%0d d=%0d u=%0b l=%0b",
                     want.index_a, want.index_b, want.jaccard_frac, want.dissimilarity_frac,
                     want.undefined_ratio, want.last_result, got.index_a, got.index_b,
                     got.jaccard_frac, got.dissimilarity_frac, got.undefined_ratio,
                     got.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("label_overlap_jaccard regression: fail");
      $finish;
    end
  end

  // Write one register at the falling edge, for exactly one cycle.
  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_A) used_a = val;
    else used_b = val;
  endtask

  // Let everything drain, then allow the clearing pass to finish.
  task automatic drain();
    while (voxel_q.size() > 0 || overlap_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_voxel(input int a, input int b, input bit last);
    voxel_t v;
    v.label_a = a[2:0];
    v.label_b = b[2:0];
    v.last_voxel = last;
    voxel_q.push_back(v);
  endtask

  // Random run: labels 0 to 7, some beyond the in-use setting; the final voxel is flagged last.
  task automatic random_run(input int len);
    for (int k = 0; k < len; k++)
      push_voxel($urandom_range(7), $urandom_range(7), k == len - 1);
  endtask

  initial begin
    int sent;
    for (int k = 0; k < 64; k++) joint_hist[k] = '0;
    for (int k = 0; k < 8; k++) begin
      hist_a[k] = '0;
      hist_b[k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme labels, out-of-use drops, zero denominators.
    drv_burst = 1'b1;
    push_voxel(0, 0, 0);
    push_voxel(7, 7, 0);
    push_voxel(7, 0, 0);
    push_voxel(0, 7, 0);
    push_voxel(3, 5, 1);
    push_voxel(2, 2, 1);
    drain();
    write_reg(CFG_IDX_A, 4'd1);
    write_reg(CFG_IDX_B, 4'd1);
    push_voxel(0, 0, 0);
    push_voxel(1, 0, 0);
    push_voxel(0, 1, 1);
    push_voxel(5, 6, 1);
    drain();
    // Register zero emits nothing; above-max acts as eight.
    write_reg(CFG_IDX_A, 4'd0);
    write_reg(CFG_IDX_B, 4'd15);
    push_voxel(0, 3, 0);
    push_voxel(1, 4, 1);
    drain();
    write_reg(CFG_IDX_A, 4'd15);
    write_reg(CFG_IDX_B, 4'd3);
    push_voxel(6, 2, 0);
    push_voxel(6, 5, 1);
    drain();
    drv_burst = 1'b0;

    // Long receiver hold-off while voxels keep coming.
    write_reg(CFG_IDX_A, 4'd2);
    write_reg(CFG_IDX_B, 4'd2);
    hold_off = 1'b1;
    random_run(6);
    random_run(8);
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Random phases over several settings.
    sent = 30;
    while (sent < 330) begin
      write_reg(CFG_IDX_A, CFG_W'($urandom_range(8, 1)));
      write_reg(CFG_IDX_B, CFG_W'($urandom_range(8, 1)));
      for (int r = 0; r < 3; r++) begin
        int len;
        len = $urandom_range(12, 1);
        random_run(len);
        sent += len;
      end
      drain();
    end

    $display("covered %0d voxels, %0d result words (%0d with undefined ratio)",
             n_words_in, n_results, n_undef);
    if (errors == 0) $display("label_overlap_jaccard regression: pass");
    else $display("label_overlap_jaccard regression: fail");
    $finish;
  end
endmodule
